// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the interpolator RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a synchronous reset that disables the check.
`define PLIH_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication form: the consequent must hold in the same cycle.
`define PLIH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/plih_pkg.sv =====
// Shared constants and codes for the piecewise-linear interpolator.
// Depends on nothing; used by the muldiv and top modules of the block.
`default_nettype none

package plih_pkg;

  // Default number of table nodes.
  localparam int TABLE_DEPTH_DEF = 256;

  // Search constants.
  localparam int CACHE_WINDOW = 8;
  localparam int LINEAR_LIMIT = 4;
  localparam int GUESS_MARGIN = 3;

  // Field widths.
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 8;
  localparam int LEN_W   = 9;
  localparam int CASE_W  = 3;

  // Quotient clamp: the magnitude added to y0 never exceeds two to the fortieth.
  localparam int QUO_W = 41;

  // Register reset value.
  localparam logic [LEN_W-1:0] TABLE_LENGTH_RST = 9'd2;

  // Request types.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Result codes carried on bracket_case.
  localparam logic [CASE_W-1:0] CASE_BELOW  = 3'd0;
  localparam logic [CASE_W-1:0] CASE_ABOVE  = 3'd1;
  localparam logic [CASE_W-1:0] CASE_LAST   = 3'd2;
  localparam logic [CASE_W-1:0] CASE_EXACT  = 3'd3;
  localparam logic [CASE_W-1:0] CASE_INTERP = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/core/plih_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; holds the abscissa and ordinate tables.
`default_nettype none

module plih_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/plih_muldiv.sv =====
// Multi-cycle unsigned multiply then restoring divide: min(a*b/d, 2^40).
// Depends on plih_pkg for the quotient width.
`default_nettype none

module plih_muldiv (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [32:0]               op_a,
  input  wire logic [32:0]               op_b,
  input  wire logic [32:0]               op_d,
  output logic                           done,
  output logic [plih_pkg::QUO_W-1:0]     quo
);

  localparam int NUM_W = 65;

  typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_ADD, M_DIV} mstate_t;

  mstate_t           state;
  logic [32:0]       ma;
  logic [32:0]       mb;
  logic [32:0]       md;
  logic [49:0]       preg;
  logic [NUM_W-1:0]  num;
  logic [32:0]       rem;
  logic [6:0]        count;

  logic [16:0]       mul_a;
  logic [49:0]       prod;
  logic [33:0]       rem_sh;
  logic [33:0]       rem_sub;
  logic              take;

  // One 17x33 multiplier serves both halves of the first operand.
  always_comb begin
    mul_a   = (state == M_LO) ? ma[16:0] : {1'b0, ma[32:17]};
    prod    = 50'(mul_a) * 50'(mb);
    rem_sh  = {rem, num[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, md};
    take    = (rem_sh >= {1'b0, md});
  end

  // Sequencer: low partial product, high partial product, sum, then one
  // quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= (state == M_DIV) && (count == 7'd1);
      case (state)
        M_IDLE: begin
          if (start) begin
            ma    <= op_a;
            mb    <= op_b;
            md    <= op_d;
            state <= M_LO;
          end
        end
        M_LO: begin
          preg  <= prod;
          state <= M_HI;
        end
        M_HI: begin
          num   <= NUM_W'(preg);
          preg  <= prod;
          state <= M_ADD;
        end
        M_ADD: begin
          num   <= num + (NUM_W'(preg) << 17);
          rem   <= '0;
          count <= 7'(NUM_W);
          state <= M_DIV;
        end
        M_DIV: begin
          rem   <= take ? rem_sub[32:0] : rem_sh[32:0];
          num   <= {num[NUM_W-2:0], take};
          count <= count - 7'd1;
          if (count == 7'd1) begin
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  // Clamp the quotient to two to the fortieth.
  always_comb begin
    if (num > (NUM_W'(1) << (plih_pkg::QUO_W - 1))) begin
      quo = plih_pkg::QUO_W'(1) << (plih_pkg::QUO_W - 1);
    end else begin
      quo = num[plih_pkg::QUO_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/piecewise_linear_interp_with_hint_top.sv =====
// Top level of the piecewise-linear interpolator with a carried search hint.
// Depends on plih_pkg, plih_ram, plih_muldiv and assert_macros.svh.
//
// Usage: the input channel (in_valid/in_stall) carries load and query
// transactions. A load writes one node into both tables in the cycle it is
// accepted and gives no result. A query searches the abscissa table, starting
// from the bracket found by the previous query, and gives one result on the
// output channel (out_valid/out_stall): y_out and bracket_case.
// Each table read goes through the registered memory port, and each bisection
// step adds one more read. A key above the table gives its result after the
// read of the last node alone. An interpolated result also passes through the
// serial multiply and the 65-step divide. One query is in work at a time.
// The result sits in an output register; while it waits, the next transaction
// may be accepted, and a new result waits until the register is free.
// cfg_wr_en writes table_length (reset value 2); the user writes it only while
// the block is idle, which is not enforced. Synchronous reset clears the
// hint, the register and the control state; tables are undefined until written.
`default_nettype none
`include "assert_macros.svh"

module piecewise_linear_interp_with_hint_top #(
  parameter int TABLE_DEPTH = plih_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [plih_pkg::LEN_W-1:0]      cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            req_type,
  input  wire logic [plih_pkg::INDEX_W-1:0]    point_index,
  input  wire logic signed [plih_pkg::DATA_W-1:0] x_value,
  input  wire logic signed [plih_pkg::DATA_W-1:0] y_value,
  input  wire logic                            start_batch,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [plih_pkg::DATA_W-1:0]   y_out,
  output logic [plih_pkg::CASE_W-1:0]          bracket_case
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = AW + 1;
  localparam int CW = (LW > plih_pkg::LEN_W) ? LW : plih_pkg::LEN_W;

  typedef enum logic [4:0] {
    S_IDLE, S_LAST, S_FIRST, S_LIN, S_G, S_GM, S_GW8, S_GP1, S_GP2, S_GP8,
    S_BIS, S_BM, S_FIN, S_YONLY, S_N0, S_N1, S_DIV, S_OUT
  } state_t;

  state_t                       state;
  logic                         wait_rd;
  logic [AW-1:0]                addr;
  logic [plih_pkg::LEN_W-1:0]   table_length;
  logic signed [31:0]           key;
  logic [LW-1:0]                len;
  logic [LW-1:0]                guess;
  logic [LW-1:0]                g;
  logic [LW-1:0]                lo;
  logic [LW-1:0]                hi;
  logic [LW-1:0]                lin_i;
  logic [LW-1:0]                jreg;
  logic [LW-1:0]                hint;
  logic signed [31:0]           x0;
  logic signed [31:0]           y0;
  logic signed [31:0]           y_res;
  logic [plih_pkg::CASE_W-1:0]  code_res;
  logic                         neg;
  logic                         md_start;
  logic [32:0]                  md_a;
  logic [32:0]                  md_b;
  logic [32:0]                  md_d;
  logic                         md_done;
  logic [plih_pkg::QUO_W-1:0]   md_quo;

  logic [31:0]                  a_rdata;
  logic [31:0]                  o_rdata;
  logic signed [31:0]           a_s;
  logic                         ram_we;
  logic                         in_take;
  logic                         md_fire;
  logic                         out_load;
  logic [CW-1:0]                len_wide;
  logic [LW-1:0]                len_eff;
  logic [LW-1:0]                gc;
  logic [LW-1:0]                mid;
  logic signed [32:0]           dx;
  logic signed [32:0]           dy;
  logic signed [32:0]           dk;
  logic signed [41:0]           sum;
  logic signed [31:0]           sat;

  // Input handshake and table writes.
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign ram_we   = in_take && (req_type == plih_pkg::REQ_LOAD) &&
                    (CW'(point_index) < CW'(TABLE_DEPTH));
  assign a_s      = $signed(a_rdata);

  // Divider launch and output register load.
  assign md_fire  = !wait_rd && (state == S_N1) && (x0 != key) && (dx != '0);
  assign out_load = !wait_rd && (state == S_OUT) && (!out_valid || !out_stall);

  plih_ram #(.WIDTH(plih_pkg::DATA_W), .DEPTH(TABLE_DEPTH)) u_abscissa (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(point_index)),
    .wdata (x_value),
    .raddr (addr),
    .rdata (a_rdata)
  );

  plih_ram #(.WIDTH(plih_pkg::DATA_W), .DEPTH(TABLE_DEPTH)) u_ordinate (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(point_index)),
    .wdata (y_value),
    .raddr (addr),
    .rdata (o_rdata)
  );

  plih_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .op_a  (md_a),
    .op_b  (md_b),
    .op_d  (md_d),
    .done  (md_done),
    .quo   (md_quo)
  );

  // Effective length, clamped guess, bisection midpoint, the spans and the saturated sum.
  always_comb begin
    len_wide = CW'(table_length);
    if (len_wide == '0) begin
      len_eff = LW'(1);
    end else if (len_wide > CW'(TABLE_DEPTH)) begin
      len_eff = LW'(TABLE_DEPTH);
    end else begin
      len_eff = len_wide[LW-1:0];
    end
    gc = (guess > len - LW'(plih_pkg::GUESS_MARGIN)) ?
         len - LW'(plih_pkg::GUESS_MARGIN) : guess;
    if (gc < LW'(1)) begin
      gc = LW'(1);
    end
    mid = lo + ((hi - lo) >> 1);
    dx  = $signed({a_s[31], a_s}) - $signed({x0[31], x0});
    dy  = $signed({o_rdata[31], o_rdata}) - $signed({y0[31], y0});
    dk  = $signed({key[31], key}) - $signed({x0[31], x0});
    sum = neg ? ($signed({{10{y0[31]}}, y0}) - $signed({1'b0, md_quo})) :
                ($signed({{10{y0[31]}}, y0}) + $signed({1'b0, md_quo}));
    if (sum > 42'sd2147483647) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum < -42'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= plih_pkg::TABLE_LENGTH_RST;
    end else if (cfg_wr_en) begin
      table_length <= cfg_wr_data;
    end
  end

  // Search sequencer: every table read registers an address and then the RAM
  // registers the data, so a consuming state first sits out the wait cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wait_rd   <= 1'b0;
      hint      <= '0;
      md_start  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      md_start <= md_fire;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (wait_rd) begin
        wait_rd <= 1'b0;
      end else begin
        case (state)
          S_IDLE: begin
            if (in_take && (req_type == plih_pkg::REQ_QUERY)) begin
              key     <= x_value;
              len     <= len_eff;
              guess   <= start_batch ? '0 : hint;
              addr    <= AW'(len_eff - LW'(1));
              wait_rd <= 1'b1;
              state   <= S_LAST;
            end
          end
          S_LAST: begin
            if (key > a_s) begin
              y_res    <= o_rdata;
              code_res <= plih_pkg::CASE_ABOVE;
              hint     <= len;
              state    <= S_OUT;
            end else begin
              addr    <= '0;
              wait_rd <= 1'b1;
              state   <= S_FIRST;
            end
          end
          S_FIRST: begin
            if (key < a_s) begin
              y_res    <= o_rdata;
              code_res <= plih_pkg::CASE_BELOW;
              hint     <= '0;
              state    <= S_OUT;
            end else if (len <= LW'(plih_pkg::LINEAR_LIMIT)) begin
              if (len > LW'(1)) begin
                lin_i   <= LW'(1);
                addr    <= AW'(1);
                wait_rd <= 1'b1;
                state   <= S_LIN;
              end else begin
                jreg  <= '0;
                state <= S_FIN;
              end
            end else begin
              g       <= gc;
              addr    <= AW'(gc);
              wait_rd <= 1'b1;
              state   <= S_G;
            end
          end
          // Linear scan for short tables.
          S_LIN: begin
            if (key >= a_s) begin
              if (lin_i + LW'(1) < len) begin
                lin_i   <= lin_i + LW'(1);
                addr    <= AW'(lin_i + LW'(1));
                wait_rd <= 1'b1;
              end else begin
                jreg  <= lin_i;
                state <= S_FIN;
              end
            end else begin
              jreg  <= lin_i - LW'(1);
              state <= S_FIN;
            end
          end
          S_G: begin
            wait_rd <= 1'b1;
            if (key < a_s) begin
              addr  <= AW'(g - LW'(1));
              state <= S_GM;
            end else begin
              addr  <= AW'(g + LW'(1));
              state <= S_GP1;
            end
          end
          S_GM: begin
            if (key < a_s) begin
              hi <= g - LW'(1);
              lo <= '0;
              if (g > LW'(plih_pkg::CACHE_WINDOW)) begin
                addr    <= AW'(g - LW'(plih_pkg::CACHE_WINDOW));
                wait_rd <= 1'b1;
                state   <= S_GW8;
              end else begin
                state <= S_BIS;
              end
            end else begin
              jreg  <= g - LW'(1);
              state <= S_FIN;
            end
          end
          S_GW8: begin
            if (key >= a_s) begin
              lo <= g - LW'(plih_pkg::CACHE_WINDOW);
            end
            state <= S_BIS;
          end
          S_GP1: begin
            if (key < a_s) begin
              jreg  <= g;
              state <= S_FIN;
            end else begin
              addr    <= AW'(g + LW'(2));
              wait_rd <= 1'b1;
              state   <= S_GP2;
            end
          end
          S_GP2: begin
            if (key < a_s) begin
              jreg  <= g + LW'(1);
              state <= S_FIN;
            end else begin
              lo <= g + LW'(2);
              hi <= len;
              if ((LW+1)'(g) + (LW+1)'(plih_pkg::CACHE_WINDOW + 1) < (LW+1)'(len)) begin
                addr    <= AW'(g + LW'(plih_pkg::CACHE_WINDOW));
                wait_rd <= 1'b1;
                state   <= S_GP8;
              end else begin
                state <= S_BIS;
              end
            end
          end
          S_GP8: begin
            if (key < a_s) begin
              hi <= g + LW'(plih_pkg::CACHE_WINDOW);
            end
            state <= S_BIS;
          end
          // Bisection over the remaining window.
          S_BIS: begin
            if (lo < hi) begin
              addr    <= AW'(mid);
              wait_rd <= 1'b1;
              state   <= S_BM;
            end else if (lo == '0) begin
              hint     <= '0;
              code_res <= plih_pkg::CASE_BELOW;
              addr     <= '0;
              wait_rd  <= 1'b1;
              state    <= S_YONLY;
            end else begin
              jreg    <= lo - LW'(1);
              state   <= S_FIN;
            end
          end
          S_BM: begin
            if (key >= a_s) begin
              lo <= mid + LW'(1);
            end else begin
              hi <= mid;
            end
            state <= S_BIS;
          end
          // Bracket found: store the hint and fetch the nodes.
          S_FIN: begin
            hint    <= jreg;
            addr    <= AW'(jreg);
            wait_rd <= 1'b1;
            if (jreg == len - LW'(1)) begin
              code_res <= plih_pkg::CASE_LAST;
              state    <= S_YONLY;
            end else begin
              state <= S_N0;
            end
          end
          S_YONLY: begin
            y_res <= o_rdata;
            state <= S_OUT;
          end
          S_N0: begin
            x0      <= a_s;
            y0      <= o_rdata;
            addr    <= AW'(jreg + LW'(1));
            wait_rd <= 1'b1;
            state   <= S_N1;
          end
          S_N1: begin
            if (x0 == key) begin
              y_res    <= y0;
              code_res <= plih_pkg::CASE_EXACT;
              state    <= S_OUT;
            end else if (dx == '0) begin
              y_res    <= y0;
              code_res <= plih_pkg::CASE_INTERP;
              state    <= S_OUT;
            end else begin
              md_a     <= dy[32] ? 33'(-dy) : 33'(dy);
              md_b     <= dk[32] ? 33'(-dk) : 33'(dk);
              md_d     <= dx[32] ? 33'(-dx) : 33'(dx);
              neg      <= dy[32] ^ dk[32] ^ dx[32];
              state    <= S_DIV;
            end
          end
          S_DIV: begin
            if (md_done) begin
              y_res    <= sat;
              code_res <= plih_pkg::CASE_INTERP;
              state    <= S_OUT;
            end
          end
          // Hand the result to the output register once it is free.
          S_OUT: begin
            if (out_load) begin
              y_out        <= y_res;
              bracket_case <= code_res;
              state        <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // The stored hint never exceeds the table depth.
  `PLIH_ASSERT(a_hint_bound, clk, rst, hint <= LW'(TABLE_DEPTH), "search hint out of range")
  // The divider only finishes while the sequencer waits for it.
  `PLIH_ASSERT_IMP(a_div_done, clk, rst, md_done, state == S_DIV, "divider finished unexpectedly")
  // A presented result carries a defined code.
  `PLIH_ASSERT_IMP(a_case_code, clk, rst, out_valid, bracket_case <= plih_pkg::CASE_INTERP, "bad result code")
  // A read wait never falls in the idle state.
  `PLIH_ASSERT_IMP(a_wait_idle, clk, rst, wait_rd, state != S_IDLE, "read wait while idle")

endmodule

`default_nettype wire
